FILE: design/bate_pkg.sv
// shared types and codes for the bounded array table engine
`timescale 1ns / 1ps
`default_nettype none

package bate_pkg;

    // fixed field widths
    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int RIDX_W   = 6;
    localparam int STATUS_W = 3;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MAX    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SORT   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd6;
    localparam logic [KIND_W-1:0] KIND_DUMP   = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    // flags from the shared compare unit
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

`default_nettype wire

FILE: design/bounded_array_table_engine_top.sv
// top level: sequencer, element ram, compare unit and result register
//
// Keeps up to CAPACITY signed 32-bit words in a single-port-read ram and runs one
// operation per transaction: clear, append, insert, delete, max, sort, search or dump.
// s_ready is high only while the sequencer is idle; every element read goes through
// the one ram read port and every comparison through the one shared compare unit.
// Search and dump give one result per match or element, the final one flagged by
// m_last; a full result register stalls the sequencer until m_ready takes the
// transaction.
`timescale 1ns / 1ps
`default_nettype none

module bounded_array_table_engine_top #(
    parameter int CAPACITY = 64
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // input channel
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire [bate_pkg::KIND_W-1:0]            s_kind,
    input  wire [bate_pkg::POS_W-1:0]             s_position,
    input  wire signed [bate_pkg::DATA_W-1:0]     s_value,
    // result channel
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic signed [bate_pkg::DATA_W-1:0]    m_result_value,
    output logic [bate_pkg::RIDX_W-1:0]           m_result_index,
    output logic [bate_pkg::STATUS_W-1:0]         m_status,
    output logic                                  m_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DECODE    = 5'd1;
    localparam logic [4:0] S_EMIT      = 5'd2;
    localparam logic [4:0] S_INS_RD    = 5'd3;
    localparam logic [4:0] S_INS_WR    = 5'd4;
    localparam logic [4:0] S_DEL_RD    = 5'd5;
    localparam logic [4:0] S_DEL_WR    = 5'd6;
    localparam logic [4:0] S_MAX_RD    = 5'd7;
    localparam logic [4:0] S_MAX_CMP   = 5'd8;
    localparam logic [4:0] S_SORT_I    = 5'd9;
    localparam logic [4:0] S_SORT_KEY  = 5'd10;
    localparam logic [4:0] S_SORT_JRD  = 5'd11;
    localparam logic [4:0] S_SORT_JCMP = 5'd12;
    localparam logic [4:0] S_SRCH_RD   = 5'd13;
    localparam logic [4:0] S_SRCH_CMP  = 5'd14;
    localparam logic [4:0] S_DUMP_RD   = 5'd15;
    localparam logic [4:0] S_DUMP_OUT  = 5'd16;

    // control state
    logic [4:0]                          state_reg, state_next;
    logic [LW-1:0]                       len_reg, len_next;
    logic                                pend_reg, pend_next;
    logic                                m_valid_reg, m_valid_next;

    // working registers
    logic [LW-1:0]                       idx_reg, idx_next;
    logic [LW-1:0]                       j_reg, j_next;
    logic [bate_pkg::DATA_W-1:0]         key_reg, key_next;
    logic [bate_pkg::KIND_W-1:0]         kind_reg, kind_next;
    logic [bate_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [bate_pkg::DATA_W-1:0]         val_reg, val_next;
    logic [bate_pkg::DATA_W-1:0]         res_value_reg, res_value_next;
    logic [bate_pkg::RIDX_W-1:0]         res_index_reg, res_index_next;
    logic [bate_pkg::STATUS_W-1:0]       res_status_reg, res_status_next;

    // output payload registers
    logic [bate_pkg::DATA_W-1:0]         out_value_reg, out_value_next;
    logic [bate_pkg::RIDX_W-1:0]         out_index_reg, out_index_next;
    logic [bate_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;
    logic                                out_last_reg, out_last_next;

    // ram and compare unit hookup
    logic                                ram_we;
    logic [AW-1:0]                       ram_waddr;
    logic [bate_pkg::DATA_W-1:0]         ram_wdata;
    logic                                ram_re;
    logic [AW-1:0]                       ram_raddr;
    logic [bate_pkg::DATA_W-1:0]         ram_rdata;
    logic [bate_pkg::DATA_W-1:0]         cmp_a;
    logic [bate_pkg::DATA_W-1:0]         cmp_b;
    bate_pkg::cmp_res_t                  cmp_res;

    // emit request into the result register
    logic                                emit;
    logic [bate_pkg::DATA_W-1:0]         e_value;
    logic [bate_pkg::RIDX_W-1:0]         e_index;
    logic [bate_pkg::STATUS_W-1:0]       e_status;
    logic                                e_last;

    // helpers
    logic                                out_free;
    logic                                in_accept;
    logic [LW-1:0]                       idx_m1;
    logic [LW-1:0]                       idx_p1;
    logic [LW-1:0]                       j_m1;
    logic [bate_pkg::POS_W-1:0]          pos_m1;
    logic                                is_full;

    assign out_free  = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign idx_m1    = idx_reg - LW'(1);
    assign idx_p1    = idx_reg + LW'(1);
    assign j_m1      = j_reg - LW'(1);
    assign pos_m1    = pos_reg - bate_pkg::POS_W'(1);
    assign is_full   = (len_reg >= LW'(CAPACITY));

    bate_ram #(
        .WIDTH (bate_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    bate_cmp u_cmp (
        .op_a (cmp_a),
        .op_b (cmp_b),
        .res  (cmp_res)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        pend_next       = pend_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        key_next        = key_reg;
        kind_next       = kind_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        res_value_next  = res_value_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        cmp_a           = '0;
        cmp_b           = '0;
        emit            = 1'b0;
        e_value         = '0;
        e_index         = '0;
        e_status        = bate_pkg::ST_OK;
        e_last          = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    kind_next  = s_kind;
                    pos_next   = s_position;
                    val_next   = s_value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE: begin
                res_value_next  = '0;
                res_index_next  = '0;
                res_status_next = bate_pkg::ST_OK;
                idx_next        = '0;
                pend_next       = 1'b0;
                state_next      = S_EMIT;
                unique case (kind_reg)
                    bate_pkg::KIND_CLEAR: begin
                        len_next = '0;
                    end
                    bate_pkg::KIND_APPEND: begin
                        if (is_full) begin
                            res_status_next = bate_pkg::ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = len_reg[AW-1:0];
                            ram_wdata = val_reg;
                            len_next  = len_reg + LW'(1);
                        end
                    end
                    bate_pkg::KIND_INSERT: begin
                        if (is_full) begin
                            res_status_next = bate_pkg::ST_FULL;
                        end else if (pos_reg == '0 ||
                                     8'(pos_reg) > 8'(len_reg) + 8'd1) begin
                            res_status_next = bate_pkg::ST_BADPOS;
                        end else begin
                            idx_next   = len_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    bate_pkg::KIND_DELETE: begin
                        if (len_reg == '0) begin
                            res_status_next = bate_pkg::ST_EMPTY;
                        end else if (pos_reg == '0 || 8'(pos_reg) > 8'(len_reg)) begin
                            res_status_next = bate_pkg::ST_BADPOS;
                        end else begin
                            idx_next   = LW'(pos_m1);
                            state_next = S_DEL_RD;
                        end
                    end
                    bate_pkg::KIND_MAX: begin
                        if (len_reg == '0) begin
                            res_status_next = bate_pkg::ST_EMPTY;
                        end else begin
                            state_next = S_MAX_RD;
                        end
                    end
                    bate_pkg::KIND_SORT: begin
                        idx_next   = LW'(1);
                        state_next = S_SORT_I;
                    end
                    bate_pkg::KIND_SEARCH: begin
                        if (len_reg == '0) begin
                            res_status_next = bate_pkg::ST_EMPTY;
                        end else begin
                            state_next = S_SRCH_RD;
                        end
                    end
                    bate_pkg::KIND_DUMP: begin
                        if (len_reg == '0) begin
                            res_status_next = bate_pkg::ST_EMPTY;
                        end else begin
                            state_next = S_DUMP_RD;
                        end
                    end
                    default: begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            // single final result from the result registers
            S_EMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_value    = res_value_reg;
                    e_index    = res_index_reg;
                    e_status   = res_status_reg;
                    e_last     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // insert: shift the tail up one slot, top down
            S_INS_RD: begin
                if (8'(idx_reg) >= 8'(pos_reg)) begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_m1[AW-1:0];
                    state_next = S_INS_WR;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_m1[AW-1:0];
                    ram_wdata  = val_reg;
                    len_next   = len_reg + LW'(1);
                    state_next = S_EMIT;
                end
            end

            S_INS_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_m1;
                state_next = S_INS_RD;
            end

            // delete: shift the tail down one slot, bottom up
            S_DEL_RD: begin
                if (idx_p1 < len_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_p1[AW-1:0];
                    state_next = S_DEL_WR;
                end else begin
                    len_next   = len_reg - LW'(1);
                    state_next = S_EMIT;
                end
            end

            S_DEL_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_p1;
                state_next = S_DEL_RD;
            end

            // max: running best kept in the result registers
            S_MAX_RD: begin
                if (idx_reg < len_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[AW-1:0];
                    state_next = S_MAX_CMP;
                end else begin
                    state_next = S_EMIT;
                end
            end

            S_MAX_CMP: begin
                cmp_a = res_value_reg;
                cmp_b = ram_rdata;
                if (idx_reg == '0 || cmp_res.lt) begin
                    res_value_next = ram_rdata;
                    res_index_next = bate_pkg::RIDX_W'(idx_reg);
                end
                idx_next   = idx_p1;
                state_next = S_MAX_RD;
            end

            // sort: outer pass picks the key
            S_SORT_I: begin
                if (idx_reg < len_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[AW-1:0];
                    state_next = S_SORT_KEY;
                end else begin
                    state_next = S_EMIT;
                end
            end

            S_SORT_KEY: begin
                key_next   = ram_rdata;
                j_next     = idx_reg;
                state_next = S_SORT_JRD;
            end

            // sort: inner walk down while the key is smaller
            S_SORT_JRD: begin
                if (j_reg != '0) begin
                    ram_re     = 1'b1;
                    ram_raddr  = j_m1[AW-1:0];
                    state_next = S_SORT_JCMP;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = j_reg[AW-1:0];
                    ram_wdata  = key_reg;
                    idx_next   = idx_p1;
                    state_next = S_SORT_I;
                end
            end

            S_SORT_JCMP: begin
                cmp_a     = key_reg;
                cmp_b     = ram_rdata;
                ram_we    = 1'b1;
                ram_waddr = j_reg[AW-1:0];
                if (cmp_res.lt) begin
                    ram_wdata  = ram_rdata;
                    j_next     = j_m1;
                    state_next = S_SORT_JRD;
                end else begin
                    ram_wdata  = key_reg;
                    idx_next   = idx_p1;
                    state_next = S_SORT_I;
                end
            end

            // search: a match is held back until the next one or the end
            S_SRCH_RD: begin
                if (idx_reg < len_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[AW-1:0];
                    state_next = S_SRCH_CMP;
                end else begin
                    if (!pend_reg) begin
                        res_status_next = bate_pkg::ST_NOTFOUND;
                        res_index_next  = '0;
                    end
                    state_next = S_EMIT;
                end
            end

            S_SRCH_CMP: begin
                cmp_a = ram_rdata;
                cmp_b = val_reg;
                if (cmp_res.eq) begin
                    if (!pend_reg || out_free) begin
                        if (pend_reg) begin
                            emit     = 1'b1;
                            e_index  = res_index_reg;
                            e_status = bate_pkg::ST_OK;
                            e_last   = 1'b0;
                        end
                        pend_next      = 1'b1;
                        res_index_next = bate_pkg::RIDX_W'(idx_reg);
                        idx_next       = idx_p1;
                        state_next     = S_SRCH_RD;
                    end
                end else begin
                    idx_next   = idx_p1;
                    state_next = S_SRCH_RD;
                end
            end

            // dump: one result per element
            S_DUMP_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg[AW-1:0];
                state_next = S_DUMP_OUT;
            end

            S_DUMP_OUT: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_value  = ram_rdata;
                    e_index  = bate_pkg::RIDX_W'(idx_reg);
                    e_status = bate_pkg::ST_OK;
                    e_last   = (idx_p1 == len_reg);
                    idx_next = idx_p1;
                    if (idx_p1 == len_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_DUMP_RD;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb begin
        m_valid_next    = m_valid_reg;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (emit) begin
            m_valid_next    = 1'b1;
            out_value_next  = e_value;
            out_index_next  = e_index;
            out_status_next = e_status;
            out_last_next   = e_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        j_reg          <= j_next;
        key_reg        <= key_next;
        kind_reg       <= kind_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        res_value_reg  <= res_value_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = out_value_reg;
    assign m_result_index = out_index_reg;
    assign m_status       = out_status_reg;
    assign m_last         = out_last_reg;

endmodule

`default_nettype wire

FILE: design/bate_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module bate_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                       aclk,
    input  wire                       wr_en,
    input  wire [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire [WIDTH-1:0]           wr_data,
    input  wire                       rd_en,
    input  wire [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/bate_cmp.sv
// shared signed compare unit used by max, sort and search
`timescale 1ns / 1ps
`default_nettype none

module bate_cmp (
    input  wire signed [bate_pkg::DATA_W-1:0] op_a,
    input  wire signed [bate_pkg::DATA_W-1:0] op_b,
    output bate_pkg::cmp_res_t                res
);

    // signed less-than and equality
    always_comb begin
        res.lt = (op_a < op_b);
        res.eq = (op_a == op_b);
    end

endmodule

`default_nettype wire

FILE: sim/bounded_array_table_engine_top_test.sv
// testbench for the bounded array table engine: directed table, random ops, in-line predictor
`timescale 1ns / 1ps

module bounded_array_table_engine_top_test;

    localparam int CAP          = 64;
    localparam int RANDOM_ITEMS = 86;

    // one result transaction as seen on the m_ side
    typedef struct packed {
        logic signed [bate_pkg::DATA_W-1:0] value;
        logic [bate_pkg::RIDX_W-1:0]        index;
        logic [bate_pkg::STATUS_W-1:0]      status;
        logic                               last;
    } outcome_t;

    // one row of the directed table; reply is used only when known is set
    typedef struct packed {
        logic [bate_pkg::KIND_W-1:0]        op;
        logic [bate_pkg::POS_W-1:0]         pos;
        logic signed [bate_pkg::DATA_W-1:0] operand;
        logic                               known;
        outcome_t                           reply;
    } stim_row_t;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 s_valid = 1'b0;
    wire                                  s_ready;
    logic [bate_pkg::KIND_W-1:0]          s_kind = '0;
    logic [bate_pkg::POS_W-1:0]           s_position = '0;
    logic signed [bate_pkg::DATA_W-1:0]   s_value = '0;
    wire                                  m_valid;
    logic                                 m_ready = 1'b0;
    wire signed [bate_pkg::DATA_W-1:0]    m_result_value;
    wire [bate_pkg::RIDX_W-1:0]           m_result_index;
    wire [bate_pkg::STATUS_W-1:0]         m_status;
    wire                                  m_last;

    // shadow copy of the table and the replies still owed by the block
    logic signed [bate_pkg::DATA_W-1:0]   model_words [CAP];
    int                                   model_len = 0;
    outcome_t                             awaited_replies [$];
    stim_row_t                            directed [$];
    int                                   fault_count = 0;
    bit                                   calm_send = 1'b0;
    bit                                   calm_sink = 1'b0;

    bounded_array_table_engine_top #(
        .CAPACITY(CAP)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_position     (s_position),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_result_index (m_result_index),
        .m_status       (m_status),
        .m_last         (m_last)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void push_reply(input logic signed [bate_pkg::DATA_W-1:0] v,
                                       input int i,
                                       input logic [bate_pkg::STATUS_W-1:0] st,
                                       input logic lst);
        outcome_t r;
        r.value  = v;
        r.index  = i[bate_pkg::RIDX_W-1:0];
        r.status = st;
        r.last   = lst;
        awaited_replies.push_back(r);
    endfunction

    // applies one op to the shadow table and queues the replies it owes
    function automatic void apply_table_op(input logic [bate_pkg::KIND_W-1:0] op,
                                           input logic [bate_pkg::POS_W-1:0] pos,
                                           input logic signed [bate_pkg::DATA_W-1:0] operand);
        int p;
        int j;
        int k;
        int best;
        int hits;
        logic signed [bate_pkg::DATA_W-1:0] key;
        p = int'(pos);
        hits = 0;
        case (op)
            bate_pkg::KIND_CLEAR: begin
                model_len = 0;
                push_reply(0, 0, bate_pkg::ST_OK, 1'b1);
            end
            bate_pkg::KIND_APPEND, bate_pkg::KIND_INSERT: begin
                // fullness wins over a bad position
                if (model_len >= CAP) begin
                    push_reply(0, 0, bate_pkg::ST_FULL, 1'b1);
                end else if (op == bate_pkg::KIND_INSERT &&
                             (p < 1 || p > model_len + 1)) begin
                    push_reply(0, 0, bate_pkg::ST_BADPOS, 1'b1);
                end else begin
                    if (op == bate_pkg::KIND_APPEND)
                        p = model_len + 1;
                    for (j = model_len; j > p - 1; j--)
                        model_words[j] = model_words[j-1];
                    model_words[p-1] = operand;
                    model_len++;
                    push_reply(0, 0, bate_pkg::ST_OK, 1'b1);
                end
            end
            bate_pkg::KIND_DELETE: begin
                if (model_len == 0) begin
                    push_reply(0, 0, bate_pkg::ST_EMPTY, 1'b1);
                end else if (p < 1 || p > model_len) begin
                    push_reply(0, 0, bate_pkg::ST_BADPOS, 1'b1);
                end else begin
                    for (j = p - 1; j + 1 < model_len; j++)
                        model_words[j] = model_words[j+1];
                    model_len--;
                    push_reply(0, 0, bate_pkg::ST_OK, 1'b1);
                end
            end
            bate_pkg::KIND_MAX: begin
                if (model_len == 0) begin
                    push_reply(0, 0, bate_pkg::ST_EMPTY, 1'b1);
                end else begin
                    // first slot holding the largest value
                    best = 0;
                    for (j = 1; j < model_len; j++)
                        if (model_words[j] > model_words[best])
                            best = j;
                    push_reply(model_words[best], best, bate_pkg::ST_OK, 1'b1);
                end
            end
            bate_pkg::KIND_SORT: begin
                for (j = 1; j < model_len; j++) begin
                    key = model_words[j];
                    k = j;
                    while (k > 0 && key < model_words[k-1]) begin
                        model_words[k] = model_words[k-1];
                        k--;
                    end
                    model_words[k] = key;
                end
                push_reply(0, 0, bate_pkg::ST_OK, 1'b1);
            end
            bate_pkg::KIND_SEARCH: begin
                if (model_len == 0) begin
                    push_reply(0, 0, bate_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (j = 0; j < model_len; j++)
                        if (model_words[j] == operand) begin
                            push_reply(0, j, bate_pkg::ST_OK, 1'b0);
                            hits++;
                        end
                    if (hits == 0)
                        push_reply(0, 0, bate_pkg::ST_NOTFOUND, 1'b1);
                    else
                        awaited_replies[awaited_replies.size()-1].last = 1'b1;
                end
            end
            bate_pkg::KIND_DUMP: begin
                if (model_len == 0) begin
                    push_reply(0, 0, bate_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (j = 0; j < model_len; j++)
                        push_reply(model_words[j], j, bate_pkg::ST_OK, j == model_len - 1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic stim_row_t plain(input logic [bate_pkg::KIND_W-1:0] op,
                                        input int pos,
                                        input logic signed [bate_pkg::DATA_W-1:0] operand);
        stim_row_t r;
        r = '0;
        r.op      = op;
        r.pos     = pos[bate_pkg::POS_W-1:0];
        r.operand = operand;
        return r;
    endfunction

    function automatic stim_row_t known(input logic [bate_pkg::KIND_W-1:0] op,
                                        input int pos,
                                        input logic signed [bate_pkg::DATA_W-1:0] operand,
                                        input logic [bate_pkg::STATUS_W-1:0] st,
                                        input logic signed [bate_pkg::DATA_W-1:0] rv,
                                        input int ri);
        stim_row_t r;
        r = plain(op, pos, operand);
        r.known        = 1'b1;
        r.reply.value  = rv;
        r.reply.index  = ri[bate_pkg::RIDX_W-1:0];
        r.reply.status = st;
        r.reply.last   = 1'b1;
        return r;
    endfunction

    function automatic void note_fault(input string msg);
        if (fault_count < 10)
            $display("%0t: %s", $realtime, msg);
        fault_count++;
    endfunction

    // random op mix; growth-heavy while filling the table
    function automatic logic [bate_pkg::KIND_W-1:0] draw_op(input bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (grow) begin
            if (r < 60) return bate_pkg::KIND_APPEND;
            if (r < 90) return bate_pkg::KIND_INSERT;
            if (r < 93) return bate_pkg::KIND_DELETE;
            if (r < 95) return bate_pkg::KIND_MAX;
            if (r < 96) return bate_pkg::KIND_SORT;
            if (r < 98) return bate_pkg::KIND_SEARCH;
            return bate_pkg::KIND_DUMP;
        end
        if (r < 5)  return bate_pkg::KIND_CLEAR;
        if (r < 23) return bate_pkg::KIND_APPEND;
        if (r < 43) return bate_pkg::KIND_INSERT;
        if (r < 58) return bate_pkg::KIND_DELETE;
        if (r < 68) return bate_pkg::KIND_MAX;
        if (r < 77) return bate_pkg::KIND_SORT;
        if (r < 88) return bate_pkg::KIND_SEARCH;
        return bate_pkg::KIND_DUMP;
    endfunction

    // mostly legal slots, sometimes zero or past the end
    function automatic logic [bate_pkg::POS_W-1:0] draw_position(
            input logic [bate_pkg::KIND_W-1:0] op);
        int top;
        if (op != bate_pkg::KIND_INSERT && op != bate_pkg::KIND_DELETE)
            return bate_pkg::POS_W'($urandom_range(0, 127));
        top = (op == bate_pkg::KIND_INSERT) ? model_len + 1 : model_len;
        if (top >= 1 && $urandom_range(0, 99) < 85)
            return bate_pkg::POS_W'($urandom_range(1, top));
        if ($urandom_range(0, 1) == 1)
            return '0;
        return bate_pkg::POS_W'($urandom_range(top + 1, 127));
    endfunction

    // small pool for duplicates, extremes, or any word
    function automatic logic signed [bate_pkg::DATA_W-1:0] draw_value(
            input logic [bate_pkg::KIND_W-1:0] op);
        int pick;
        if (op == bate_pkg::KIND_SEARCH && model_len > 0 && $urandom_range(0, 1) == 1)
            return model_words[$urandom_range(0, model_len - 1)];
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom_range(0, 4) - 2;
        if (pick == 4) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // drives one transaction and books its replies once accepted
    task automatic send_item(input stim_row_t row);
        int gap;
        int mark;
        gap = calm_send ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= row.op;
        s_position <= row.pos;
        s_value    <= row.operand;
        do @(posedge aclk); while (s_ready !== 1'b1);
        mark = awaited_replies.size();
        apply_table_op(row.op, row.pos, row.operand);
        if (row.known) begin
            while (awaited_replies.size() > mark)
                void'(awaited_replies.pop_back());
            awaited_replies.push_back(row.reply);
        end
    endtask

    // stimulus: directed table, then random ops
    initial begin : stimulus
        int n;
        bit filling;
        stim_row_t row;

        // empty-table corners
        directed.push_back(known(bate_pkg::KIND_CLEAR,  0, 0, bate_pkg::ST_OK,    0, 0));
        directed.push_back(known(bate_pkg::KIND_DELETE, 1, 0, bate_pkg::ST_EMPTY, 0, 0));
        directed.push_back(known(bate_pkg::KIND_MAX,    0, 0, bate_pkg::ST_EMPTY, 0, 0));
        directed.push_back(known(bate_pkg::KIND_SEARCH, 0, 0, bate_pkg::ST_EMPTY, 0, 0));
        directed.push_back(known(bate_pkg::KIND_DUMP,   0, 0, bate_pkg::ST_EMPTY, 0, 0));
        directed.push_back(known(bate_pkg::KIND_SORT,   0, 0, bate_pkg::ST_OK,    0, 0));
        directed.push_back(known(bate_pkg::KIND_INSERT, 0, 5, bate_pkg::ST_BADPOS, 0, 0));
        directed.push_back(known(bate_pkg::KIND_INSERT, 2, 5, bate_pkg::ST_BADPOS, 0, 0));
        // build up with extreme words; append ignores position
        directed.push_back(known(bate_pkg::KIND_INSERT, 1, 32'sh8000_0000,
                                 bate_pkg::ST_OK, 0, 0));
        directed.push_back(known(bate_pkg::KIND_SORT,   0, 0, bate_pkg::ST_OK, 0, 0));
        directed.push_back(known(bate_pkg::KIND_APPEND, 0, 32'sh7fff_ffff,
                                 bate_pkg::ST_OK, 0, 0));
        directed.push_back(known(bate_pkg::KIND_APPEND, 127, 0, bate_pkg::ST_OK, 0, 0));
        directed.push_back(known(bate_pkg::KIND_INSERT, 4, -1, bate_pkg::ST_OK, 0, 0));
        directed.push_back(known(bate_pkg::KIND_INSERT, 2, 0, bate_pkg::ST_OK, 0, 0));
        directed.push_back(known(bate_pkg::KIND_INSERT, 127, 3, bate_pkg::ST_BADPOS, 0, 0));
        // table now holds min, 0, max, 0, -1
        directed.push_back(known(bate_pkg::KIND_MAX, 0, 0, bate_pkg::ST_OK,
                                 32'sh7fff_ffff, 2));
        directed.push_back(plain(bate_pkg::KIND_SEARCH, 0, 0));
        directed.push_back(known(bate_pkg::KIND_SEARCH, 0, 5, bate_pkg::ST_NOTFOUND, 0, 0));
        directed.push_back(plain(bate_pkg::KIND_DUMP, 0, 0));
        directed.push_back(known(bate_pkg::KIND_SORT, 0, 0, bate_pkg::ST_OK, 0, 0));
        directed.push_back(plain(bate_pkg::KIND_DUMP, 0, 0));
        directed.push_back(known(bate_pkg::KIND_DELETE, 0, 0, bate_pkg::ST_BADPOS, 0, 0));
        directed.push_back(known(bate_pkg::KIND_DELETE, 6, 0, bate_pkg::ST_BADPOS, 0, 0));
        directed.push_back(known(bate_pkg::KIND_DELETE, 5, 0, bate_pkg::ST_OK, 0, 0));
        directed.push_back(known(bate_pkg::KIND_DELETE, 1, 0, bate_pkg::ST_OK, 0, 0));
        directed.push_back(plain(bate_pkg::KIND_MAX, 0, 0));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (n = 0; n < directed.size(); n++)
            send_item(directed[n]);

        // random: fill to capacity first, then a free mix that hits the full cases
        filling = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 16 == 0)
                calm_send = ($urandom_range(0, 3) == 0);
            if (model_len >= CAP)
                filling = 1'b0;
            row = '0;
            row.op      = draw_op(filling);
            row.pos     = draw_position(row.op);
            row.operand = draw_value(row.op);
            send_item(row);
        end
        s_valid <= 1'b0;

        // drain, then give stray replies a chance to show up
        while (awaited_replies.size() != 0)
            @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (fault_count == 0 && awaited_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // result side: random back-pressure and field-by-field compare
    initial begin : reply_sink
        outcome_t want;
        int stall;
        int seen;
        seen = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (seen % 16 == 0)
                calm_sink = ($urandom_range(0, 3) == 0);
            stall = calm_sink ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
            seen++;
            if (awaited_replies.size() == 0) begin
                note_fault($sformatf({"unexpected transaction: value %0d index %0d ",
                                      "status %0d last %0b"},
                                     m_result_value, m_result_index, m_status, m_last));
            end else begin
                want = awaited_replies.pop_front();
                if (m_result_value !== want.value || m_result_index !== want.index ||
                    m_status !== want.status || m_last !== want.last)
                    note_fault($sformatf({"mismatch: expected value %0d index %0d status %0d ",
                                          "last %0b, got value %0d index %0d status %0d last %0b"},
                                         want.value, want.index, want.status, want.last,
                                         m_result_value, m_result_index, m_status, m_last));
            end
        end
    end

    // watchdog
    initial begin : watchdog
        #16_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
design/bate_pkg.sv
design/bate_ram.sv
design/bate_cmp.sv
design/bounded_array_table_engine_top.sv
sim/bounded_array_table_engine_top_test.sv
